// ----- hw/rtl/icmper_pkg.sv -----
// Shared types and constants for the ICMP echo responder.
package icmper_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PING_ARMED  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_PORT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_TARGET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_IDENT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_SEQ    = 3'd4;

    localparam logic [7:0] TYPE_ECHO_REPLY  = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQ    = 8'd8;
    localparam logic [7:0] ICMP_CODE_ZERO   = 8'd0;
    localparam int unsigned MIN_MSG_LEN     = 8;

    typedef enum logic [1:0] {
        VERD_NONE  = 2'd0,
        VERD_DROP  = 2'd1,
        VERD_SEND  = 2'd2,
        VERD_MATCH = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [3:0]  port_id;
        logic [31:0] source_address;
        logic [7:0]  hop_limit;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        t_verdict    verdict;
        logic [15:0] reply_checksum;
        logic [7:0]  reply_hop_limit;
    } t_out_item;

    typedef struct packed {
        logic        ping_armed;
        logic [3:0]  ping_port;
        logic [31:0] ping_target;
        logic [15:0] ping_ident;
        logic [15:0] ping_seq;
    } t_ping_cfg;

endpackage

// ----- hw/rtl/icmper_cfg.sv -----
// Configuration registers for the awaited ping reply.
module icmper_cfg
    import icmper_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_ping_cfg              o_cfg
);

    t_ping_cfg r_cfg;
    t_ping_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PING_ARMED:  n_cfg.ping_armed  = i_cfg_data[0];
                CFG_PING_PORT:   n_cfg.ping_port   = i_cfg_data[3:0];
                CFG_PING_TARGET: n_cfg.ping_target = i_cfg_data[31:0];
                CFG_PING_IDENT:  n_cfg.ping_ident  = i_cfg_data[15:0];
                CFG_PING_SEQ:    n_cfg.ping_seq    = i_cfg_data[15:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- hw/rtl/icmper_core.sv -----
// Per-byte rewrite, running checksums, header capture and verdict.
module icmper_core
    import icmper_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_ping_cfg i_cfg,
    output t_out_item o_result
);

    localparam int unsigned PW = $clog2(MAX_PAYLOAD + 2);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_PAYLOAD);
    localparam logic [PW-1:0] POS_MIN = PW'(MIN_MSG_LEN);

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

    logic [15:0]   r_check_sum, n_check_sum;
    logic [15:0]   r_reply_sum, n_reply_sum;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_type, n_type;
    logic [7:0]    r_code, n_code;
    logic [15:0]   r_ident, n_ident;
    logic [15:0]   r_seq, n_seq;

    logic [7:0]  ob;
    logic [15:0] in_word;
    logic [15:0] out_word;
    logic        bad;
    logic        match;
    logic        request;

    always_comb begin
        ob      = i_item.data_byte;
        n_type  = r_type;
        n_code  = r_code;
        n_ident = r_ident;
        n_seq   = r_seq;
        case (r_pos)
            PW'(0): begin
                ob     = 8'd0;
                n_type = i_item.data_byte;
            end
            PW'(1): n_code = i_item.data_byte;
            PW'(2): ob = 8'd0;
            PW'(3): ob = 8'd0;
            PW'(4): n_ident[15:8] = i_item.data_byte;
            PW'(5): n_ident[7:0]  = i_item.data_byte;
            PW'(6): n_seq[15:8]   = i_item.data_byte;
            PW'(7): n_seq[7:0]    = i_item.data_byte;
            default: ob = i_item.data_byte;
        endcase

        // even offset is the high byte of a big-endian word
        in_word  = r_pos[0] ? {8'd0, i_item.data_byte} : {i_item.data_byte, 8'd0};
        out_word = r_pos[0] ? {8'd0, ob} : {ob, 8'd0};
        n_check_sum = oc_add(r_check_sum, in_word);
        n_reply_sum = oc_add(r_reply_sum, out_word);

        n_pos = (r_pos <= POS_MAX) ? (r_pos + PW'(1)) : r_pos;

        bad   = (n_pos < POS_MIN) || (n_pos > POS_MAX) || (n_check_sum != 16'hFFFF);
        match = (n_type == TYPE_ECHO_REPLY) && (n_code == ICMP_CODE_ZERO)
              && i_cfg.ping_armed && (i_item.port_id == i_cfg.ping_port)
              && (i_item.source_address == i_cfg.ping_target)
              && (n_ident == i_cfg.ping_ident) && (n_seq == i_cfg.ping_seq);
        request = (n_type == TYPE_ECHO_REQ) && (n_code == ICMP_CODE_ZERO);

        o_result.out_byte        = ob;
        o_result.out_last        = i_item.is_last;
        o_result.verdict         = VERD_NONE;
        o_result.reply_checksum  = 16'd0;
        o_result.reply_hop_limit = 8'd0;
        if (i_item.is_last) begin
            if (bad) begin
                o_result.verdict = VERD_DROP;
            end else if (match) begin
                o_result.verdict         = VERD_MATCH;
                o_result.reply_hop_limit = i_item.hop_limit;
            end else if (request) begin
                o_result.verdict        = VERD_SEND;
                o_result.reply_checksum = ~n_reply_sum;
            end else begin
                o_result.verdict = VERD_DROP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.is_last)) begin
            r_check_sum <= '0;
            r_reply_sum <= '0;
            r_pos       <= '0;
            r_type      <= '0;
            r_code      <= '0;
            r_ident     <= '0;
            r_seq       <= '0;
        end else if (i_advance) begin
            r_check_sum <= n_check_sum;
            r_reply_sum <= n_reply_sum;
            r_pos       <= n_pos;
            r_type      <= n_type;
            r_code      <= n_code;
            r_ident     <= n_ident;
            r_seq       <= n_seq;
        end
    end

endmodule

// ----- hw/rtl/icmp_echo_responder.sv -----
// ICMP echo responder top level: input register, core, result register.
// Path: accepted byte -> input register -> core -> result register.
// Throughput: one byte per cycle; input stalls only while both registers hold a byte
//   and the result is not taken.
// Reset: synchronous active-low i_rst_n clears packet state, config and valids.
// Packet state also clears after each last byte.
module icmp_echo_responder
    import icmper_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_advance;
    t_out_item w_result;
    t_ping_cfg w_cfg;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    icmper_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    icmper_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

`ifndef ASSERT_OFF
    a_held_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register changed before transfer to core");

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_item.verdict != VERD_NONE) == r_out_item.out_last))
        else $error("verdict does not agree with last flag");

    a_csum_only_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_item.verdict != VERD_SEND))
            |-> (r_out_item.reply_checksum == 16'd0))
        else $error("reply checksum set without send verdict");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for icmp_echo_responder: random ICMP traffic, ping config phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icmper_pkg::*;

    localparam int unsigned MAX_LEN = 2048;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_PING_SEQ + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_BYTES  = 200;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef enum int unsigned {
        PK_REQUEST,
        PK_MATCH,
        PK_NEAR_MATCH,
        PK_BAD_SUM,
        PK_OTHER,
        PK_NOISE
    } pkt_kind_e;

    class echo_board;
        t_ping_cfg   cfg;
        logic [15:0] rx_sum;
        logic [15:0] tx_sum;
        int unsigned pos;
        logic [7:0]  hdr_type;
        logic [7:0]  hdr_code;
        logic [15:0] hdr_ident;
        logic [15:0] hdr_seq;
        t_out_item   pending_replies[$];
        int unsigned errors;

        function new();
            cfg = '0;
            errors = 0;
            clear_message();
        endfunction

        static function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = a + b;
            return s[15:0] + s[16];
        endfunction

        function void clear_message();
            rx_sum = '0;
            tx_sum = '0;
            pos = 0;
            hdr_type = '0;
            hdr_code = '0;
            hdr_ident = '0;
            hdr_seq = '0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PING_ARMED:  cfg.ping_armed  = val[0];
                CFG_PING_PORT:   cfg.ping_port   = val[3:0];
                CFG_PING_TARGET: cfg.ping_target = val[31:0];
                CFG_PING_IDENT:  cfg.ping_ident  = val[15:0];
                CFG_PING_SEQ:    cfg.ping_seq    = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_byte(t_in_item it);
            t_out_item  r;
            logic [7:0] ob;
            ob = it.data_byte;
            case (pos)
                0: begin
                    ob = '0;
                    hdr_type = it.data_byte;
                end
                1: hdr_code = it.data_byte;
                2, 3: ob = '0;
                4: hdr_ident[15:8] = it.data_byte;
                5: hdr_ident[7:0]  = it.data_byte;
                6: hdr_seq[15:8]   = it.data_byte;
                7: hdr_seq[7:0]    = it.data_byte;
                default: ;
            endcase
            if ((pos % 2) == 0) begin
                rx_sum = fold_add(rx_sum, {it.data_byte, 8'h00});
                tx_sum = fold_add(tx_sum, {ob, 8'h00});
            end else begin
                rx_sum = fold_add(rx_sum, {8'h00, it.data_byte});
                tx_sum = fold_add(tx_sum, {8'h00, ob});
            end
            if (pos <= MAX_LEN) begin
                pos++;
            end
            r = '0;
            r.out_byte = ob;
            r.out_last = it.is_last;
            r.verdict = VERD_NONE;
            if (it.is_last) begin
                if (pos < MIN_MSG_LEN || pos > MAX_LEN || rx_sum != 16'hFFFF) begin
                    r.verdict = VERD_DROP;
                end else if (hdr_type == TYPE_ECHO_REPLY && hdr_code == ICMP_CODE_ZERO
                             && cfg.ping_armed && it.port_id == cfg.ping_port
                             && it.source_address == cfg.ping_target
                             && hdr_ident == cfg.ping_ident && hdr_seq == cfg.ping_seq) begin
                    r.verdict = VERD_MATCH;
                    r.reply_hop_limit = it.hop_limit;
                end else if (hdr_type == TYPE_ECHO_REQ && hdr_code == ICMP_CODE_ZERO) begin
                    r.verdict = VERD_SEND;
                    r.reply_checksum = ~tx_sum;
                end else begin
                    r.verdict = VERD_DROP;
                end
                clear_message();
            end
            pending_replies.push_back(r);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply byte, expected none, got %p", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare("out_last", 16'(want.out_last), 16'(got.out_last));
            compare("verdict", 16'(want.verdict), 16'(got.verdict));
            compare("reply_checksum", want.reply_checksum, got.reply_checksum);
            compare("reply_hop_limit", 16'(want.reply_hop_limit), 16'(got.reply_hop_limit));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_item              o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    echo_board sb;
    int unsigned burst_left = 0;
    int unsigned replies_seen = 0;

    icmp_echo_responder #(
        .MAX_PAYLOAD(MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // valid stays high across a burst; a gap lowers it between bursts
    task automatic push_byte(t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(it);
        burst_left--;
    endtask

    task automatic send_packet(pkt_kind_e kind, int unsigned len);
        logic [7:0]  msg[];
        logic [7:0]  mtype;
        logic [7:0]  mcode;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [15:0] sum;
        logic [3:0]  port;
        logic [31:0] src;
        logic [7:0]  hop;
        t_in_item    it;
        int unsigned i;
        msg = new[len];
        for (i = 0; i < len; i++) begin
            msg[i] = 8'($urandom);
        end
        port = 4'($urandom);
        src = $urandom;
        hop = 8'($urandom);
        ident = 16'($urandom);
        seq = 16'($urandom);
        mtype = TYPE_ECHO_REQ;
        mcode = ICMP_CODE_ZERO;
        if (kind == PK_MATCH || kind == PK_NEAR_MATCH) begin
            mtype = TYPE_ECHO_REPLY;
            port = sb.cfg.ping_port;
            src = sb.cfg.ping_target;
            ident = sb.cfg.ping_ident;
            seq = sb.cfg.ping_seq;
            if (kind == PK_NEAR_MATCH) begin
                case ($urandom_range(0, 5))
                    0: port ^= 4'(1 << $urandom_range(0, 3));
                    1: src ^= 32'(1) << $urandom_range(0, 31);
                    2: ident ^= 16'(1 << $urandom_range(0, 15));
                    3: seq ^= 16'(1 << $urandom_range(0, 15));
                    4: mtype = 8'($urandom_range(1, 255));
                    default: mcode = 8'($urandom_range(1, 255));
                endcase
            end
        end else if (kind == PK_OTHER) begin
            mtype = 8'($urandom);
            mcode = ($urandom_range(0, 1) == 0) ? ICMP_CODE_ZERO : 8'($urandom);
        end
        if (kind != PK_NOISE) begin
            if (len > 0) msg[0] = mtype;
            if (len > 1) msg[1] = mcode;
            if (len > 4) msg[4] = ident[15:8];
            if (len > 5) msg[5] = ident[7:0];
            if (len > 6) msg[6] = seq[15:8];
            if (len > 7) msg[7] = seq[7:0];
            if (len > 3) begin
                msg[2] = '0;
                msg[3] = '0;
                sum = '0;
                for (i = 0; i < len; i++) begin
                    sum = sb.fold_add(sum, ((i % 2) == 0) ? {msg[i], 8'h00} : {8'h00, msg[i]});
                end
                sum = ~sum;
                msg[2] = sum[15:8];
                msg[3] = sum[7:0];
                if (kind == PK_BAD_SUM) begin
                    i = $urandom_range(0, len - 1);
                    msg[i] ^= 8'(1 << $urandom_range(0, 7));
                end
            end
        end
        for (i = 0; i < len; i++) begin
            it.data_byte = msg[i];
            it.is_last = (i == len - 1);
            it.port_id = port;
            it.source_address = src;
            it.hop_limit = hop;
            push_byte(it);
        end
    endtask

    task automatic run_traffic(int unsigned byte_budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        pkt_kind_e   kind;
        sent = 0;
        while (sent < byte_budget) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 3) == 0) ? MIN_MSG_LEN : $urandom_range(MIN_MSG_LEN, 40);
            if (pick < 40) begin
                kind = PK_REQUEST;
            end else if (pick < 65) begin
                kind = PK_MATCH;
            end else if (pick < 75) begin
                kind = PK_NEAR_MATCH;
            end else if (pick < 83) begin
                kind = PK_BAD_SUM;
            end else if (pick < 90) begin
                kind = PK_OTHER;
            end else if (pick < 95) begin
                kind = ($urandom_range(0, 1) == 0) ? PK_REQUEST : PK_MATCH;
                len = $urandom_range(1, MIN_MSG_LEN - 1);
            end else begin
                kind = PK_NOISE;
                len = $urandom_range(1, 24);
            end
            send_packet(kind, len);
            sent += len;
        end
    endtask

    // leaves valid high so back-to-back writes need no drop in between
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic program_ping(logic armed, logic [3:0] port, logic [31:0] target,
                                logic [15:0] ident, logic [15:0] seq);
        write_reg(CFG_PING_ARMED, ($urandom & ~32'h1) | 32'(armed));
        write_reg(CFG_PING_PORT, ($urandom & ~32'hF) | 32'(port));
        write_reg(CFG_PING_TARGET, target);
        write_reg(CFG_PING_IDENT, ($urandom & ~32'hFFFF) | 32'(ident));
        write_reg(CFG_PING_SEQ, ($urandom & ~32'hFFFF) | 32'(seq));
        write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_reply(o_out_data);
            replies_seen++;
        end
    end

    // one long hold-off while the sender is still offering, else shifting stall patterns
    initial begin : out_side
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        bit          held;
        i_out_ready = 1'b0;
        held = 1'b0;
        forever begin
            if (!held && replies_seen >= HOLD_AFTER && i_in_valid) begin
                held = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ((k % 4) == 3);
                    default: i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: not armed, so a well-formed reply is dropped
        send_packet(PK_REQUEST, MIN_MSG_LEN);
        send_packet(PK_REQUEST, MIN_MSG_LEN + 1);
        send_packet(PK_REQUEST, 1);
        send_packet(PK_MATCH, MIN_MSG_LEN - 1);
        run_traffic(PHASE_BYTES);
        drain();

        for (phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: program_ping(1'b1, '1, '1, '1, '1);
                2: program_ping(1'b1, '0, '0, '0, '0);
                3: program_ping(1'b0, 4'($urandom), $urandom, 16'($urandom), 16'($urandom));
                default: program_ping(1'b1, 4'($urandom), $urandom, 16'($urandom),
                                      16'($urandom));
            endcase
            run_traffic(PHASE_BYTES);
            drain();
        end

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/icmper_pkg.sv
hw/rtl/icmper_cfg.sv
hw/rtl/icmper_core.sv
hw/rtl/icmp_echo_responder.sv
sim/tb.sv
